/* rtl/core/icmp6rc_pkg.sv */
// Shared types, constants and the one's-complement fold for the ICMPv6 receive checker.
// No dependencies; every core file refers to it by scoped name.
package icmp6rc_pkg;

  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned DATA_W     = 8 * WORD_BYTES;
  localparam int unsigned NB_W       = 3;

  localparam logic [15:0] NEXT_HDR_ICMPV6 = 16'd58;
  localparam logic [15:0] PTB_MIN_LEN     = 16'd48;

  // command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // result queue in the back end
  localparam int unsigned RES_DEPTH = 2;

  localparam logic [2:0] VERDICT_BAD_SUM   = 3'd0;
  localparam logic [2:0] VERDICT_ECHO_REQ  = 3'd1;
  localparam logic [2:0] VERDICT_ECHO_REP  = 3'd2;
  localparam logic [2:0] VERDICT_ERROR     = 3'd3;
  localparam logic [2:0] VERDICT_TOO_BIG   = 3'd4;
  localparam logic [2:0] VERDICT_TOO_SHORT = 3'd5;
  localparam logic [2:0] VERDICT_NDP       = 3'd6;
  localparam logic [2:0] VERDICT_UNKNOWN   = 3'd7;

  localparam logic [7:0] TYPE_DEST_UNREACH = 8'd1;
  localparam logic [7:0] TYPE_PKT_TOO_BIG  = 8'd2;
  localparam logic [7:0] TYPE_TIME_EXCEED  = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQ     = 8'd128;
  localparam logic [7:0] TYPE_ECHO_REP     = 8'd129;
  localparam logic [7:0] TYPE_NDP_FIRST    = 8'd133;
  localparam logic [7:0] TYPE_NDP_LAST     = 8'd137;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [DATA_W-1:0] data;
    logic [NB_W-1:0]   nbytes;
    logic [15:0]       len;
    logic [15:0]       psum;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [31:0] body;
    logic [15:0] csum;
    logic [15:0] reply;
    logic [63:0] orig_hi;
    logic [63:0] orig_lo;
  } res_t;

  // end-around carry fold; zero only when the input is zero
  function automatic logic [15:0] ones_fold(input logic [20:0] t);
    logic [16:0] a;
    a = {1'b0, t[15:0]} + {12'b0, t[20:16]};
    return a[15:0] + {15'b0, a[16]};
  endfunction

endpackage

/* rtl/core/icmpv6_receive_checker_core.sv */
// ICMPv6 receive checker top level: front end, command queue, back end.
// A last word passes through the command queue and then the result queue before its result is on the ports.
// Throughput: one word per cycle while full is low; the running checksum add in the back end sets this.
// A four-entry command queue and a two-entry result queue decouple the two sides.
// Reset (rst_ni, asynchronous, active low) empties both queues and zeroes all state but the queue storage.
module icmpv6_receive_checker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           first_word_i,
  input  logic                           last_word_i,
  input  logic [icmp6rc_pkg::DATA_W-1:0] data_word_i,
  input  logic [icmp6rc_pkg::NB_W-1:0]   valid_bytes_i,
  input  logic [15:0]                    payload_length_i,
  input  logic [63:0]                    src_addr_hi_i,
  input  logic [63:0]                    src_addr_lo_i,
  input  logic [63:0]                    dst_addr_hi_i,
  input  logic [63:0]                    dst_addr_lo_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     verdict_o,
  output logic [7:0]                     msg_type_o,
  output logic [7:0]                     msg_code_o,
  output logic [31:0]                    body_word_o,
  output logic [15:0]                    computed_sum_o,
  output logic [15:0]                    reply_checksum_o,
  output logic [63:0]                    orig_dst_hi_o,
  output logic [63:0]                    orig_dst_lo_o
);

  icmp6rc_pkg::cmd_t cmd_in, cmd_out;
  icmp6rc_pkg::res_t res;
  logic              q_push, q_full, q_pop, q_valid;

  icmp6rc_front u_front (
    .push             (push),
    .full             (full),
    .first_word_i     (first_word_i),
    .last_word_i      (last_word_i),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .payload_length_i (payload_length_i),
    .src_addr_hi_i    (src_addr_hi_i),
    .src_addr_lo_i    (src_addr_lo_i),
    .dst_addr_hi_i    (dst_addr_hi_i),
    .dst_addr_lo_i    (dst_addr_lo_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .cmd_o            (cmd_in)
  );

  icmp6rc_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  icmp6rc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (cmd_out),
    .q_pop_o   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .res_o     (res)
  );

  assign verdict_o        = res.verdict;
  assign msg_type_o       = res.msg_type;
  assign msg_code_o       = res.msg_code;
  assign body_word_o      = res.body;
  assign computed_sum_o   = res.csum;
  assign reply_checksum_o = res.reply;
  assign orig_dst_hi_o    = res.orig_hi;
  assign orig_dst_lo_o    = res.orig_lo;

endmodule

/* rtl/core/icmp6rc_front.sv */
// Front end: takes input words, clamps the byte count and sums the pseudo-header.
// Depends on icmp6rc_pkg.
module icmp6rc_front (
  input  logic                             push,
  output logic                             full,
  input  logic                             first_word_i,
  input  logic                             last_word_i,
  input  logic [icmp6rc_pkg::DATA_W-1:0]   data_word_i,
  input  logic [icmp6rc_pkg::NB_W-1:0]     valid_bytes_i,
  input  logic [15:0]                      payload_length_i,
  input  logic [63:0]                      src_addr_hi_i,
  input  logic [63:0]                      src_addr_lo_i,
  input  logic [63:0]                      dst_addr_hi_i,
  input  logic [63:0]                      dst_addr_lo_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output icmp6rc_pkg::cmd_t                cmd_o
);

  function automatic logic [17:0] sum64(input logic [63:0] v);
    return {2'b0, v[15:0]} + {2'b0, v[31:16]} + {2'b0, v[47:32]} + {2'b0, v[63:48]};
  endfunction

  logic [20:0] pseudo_total;

  assign pseudo_total = {3'b0, sum64(src_addr_hi_i)} + {3'b0, sum64(src_addr_lo_i)}
                      + {3'b0, sum64(dst_addr_hi_i)} + {3'b0, sum64(dst_addr_lo_i)}
                      + {5'b0, payload_length_i} + {5'b0, icmp6rc_pkg::NEXT_HDR_ICMPV6};

  always_comb begin
    cmd_o.first = first_word_i;
    cmd_o.last  = last_word_i;
    cmd_o.data  = data_word_i;
    if (valid_bytes_i > icmp6rc_pkg::NB_W'(icmp6rc_pkg::WORD_BYTES)) begin
      cmd_o.nbytes = icmp6rc_pkg::NB_W'(icmp6rc_pkg::WORD_BYTES);
    end else begin
      cmd_o.nbytes = valid_bytes_i;
    end
    cmd_o.len  = payload_length_i;
    cmd_o.psum = icmp6rc_pkg::ones_fold(pseudo_total);
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

endmodule

/* rtl/core/icmp6rc_cmd_queue.sv */
// Short command queue between front and back end.
// Depends on icmp6rc_pkg.
module icmp6rc_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  icmp6rc_pkg::cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output icmp6rc_pkg::cmd_t data_o
);

  icmp6rc_pkg::cmd_t                 mem_q [icmp6rc_pkg::QDEPTH];
  logic [icmp6rc_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [icmp6rc_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [icmp6rc_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                              do_push, do_pop;

  function automatic logic [icmp6rc_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
    return {{(icmp6rc_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  function automatic logic [icmp6rc_pkg::QPTR_W-1:0] QPTR_DIFF(
    input logic [icmp6rc_pkg::QPTR_W-1:0] a,
    input logic [icmp6rc_pkg::QPTR_W-1:0] b);
    return a - b;
  endfunction

  assign full_o  = (cnt_q == icmp6rc_pkg::QCNT_W'(icmp6rc_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + icmp6rc_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + icmp6rc_pkg::QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_ONE(do_push) - QCNT_ONE(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= icmp6rc_pkg::QCNT_W'(icmp6rc_pkg::QDEPTH))
    else $error("command queue over-filled");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != icmp6rc_pkg::QCNT_W'(icmp6rc_pkg::QDEPTH))
      |-> (QPTR_DIFF(wr_ptr_q, rd_ptr_q) == cnt_q[icmp6rc_pkg::QPTR_W-1:0]))
    else $error("command queue pointers disagree with count");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("command queue empty with pointers apart");

endmodule

/* rtl/core/icmp6rc_back.sv */
// Back end: per-word checksum, field capture, verdict, and a two-entry result queue.
// Depends on icmp6rc_pkg.
module icmp6rc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  icmp6rc_pkg::cmd_t q_data_i,
  output logic              q_pop_o,
  input  logic              pop,
  output logic              empty,
  output icmp6rc_pkg::res_t res_o
);

  logic [15:0] run_q, run_d, rep_q, rep_d;
  logic [15:0] off_q, off_d, len_q, len_d;
  logic [7:0]  type_q, type_d, code_q, code_d;
  logic [31:0] body_q, body_d;
  logic [63:0] orig_hi_q, orig_hi_d, orig_lo_q, orig_lo_d;

  icmp6rc_pkg::res_t res_mem_q [icmp6rc_pkg::RES_DEPTH];
  logic              res_wr_q, res_rd_q;
  logic [1:0]        res_cnt_q, res_cnt_d;
  icmp6rc_pkg::res_t res_d;
  logic              go, res_push, res_pop;

  assign go       = q_valid_i && (!q_data_i.last || res_cnt_q != 2'(icmp6rc_pkg::RES_DEPTH));
  assign q_pop_o  = go;
  assign res_push = go && q_data_i.last;
  assign res_pop  = pop && !empty;
  assign empty    = (res_cnt_q == 2'd0);
  assign res_o    = res_mem_q[res_rd_q];

  always_comb begin
    logic [15:0] base_off;
    logic [16:0] off_sum;
    logic [15:0] off_b;
    logic [7:0]  bt, rb;
    logic [17:0] run_add, rep_add;
    logic [16:0] off_tot;
    logic [15:0] csum;

    if (q_data_i.first) begin
      base_off  = '0;
      len_d     = q_data_i.len;
      type_d    = '0;
      code_d    = '0;
      body_d    = '0;
      orig_hi_d = '0;
      orig_lo_d = '0;
      run_d     = q_data_i.psum;
      rep_d     = q_data_i.psum;
    end else begin
      base_off  = off_q;
      len_d     = len_q;
      type_d    = type_q;
      code_d    = code_q;
      body_d    = body_q;
      orig_hi_d = orig_hi_q;
      orig_lo_d = orig_lo_q;
      run_d     = run_q;
      rep_d     = rep_q;
    end

    run_add = '0;
    rep_add = '0;
    for (int i = 0; i < icmp6rc_pkg::WORD_BYTES; i++) begin
      off_sum = {1'b0, base_off} + 17'(i);
      off_b   = off_sum[16] ? 16'hFFFF : off_sum[15:0];
      bt      = q_data_i.data[icmp6rc_pkg::DATA_W-1-8*i -: 8];
      if (off_b == 16'd0) begin
        rb = icmp6rc_pkg::TYPE_ECHO_REP;
      end else if (off_b == 16'd2 || off_b == 16'd3) begin
        rb = 8'd0;
      end else begin
        rb = bt;
      end
      if (icmp6rc_pkg::NB_W'(i) < q_data_i.nbytes) begin
        if (off_b == 16'd0) begin
          type_d = bt;
        end else if (off_b == 16'd1) begin
          code_d = bt;
        end else if (off_b >= 16'd4 && off_b <= 16'd7) begin
          body_d[{~off_b[1:0], 3'b000} +: 8] = bt;
        end else if (off_b >= 16'd32 && off_b <= 16'd47) begin
          // bytes 32..39 form the upper half of the embedded address
          if (off_b[3]) begin
            orig_lo_d[{~off_b[2:0], 3'b000} +: 8] = bt;
          end else begin
            orig_hi_d[{~off_b[2:0], 3'b000} +: 8] = bt;
          end
        end
        if (off_b < len_d) begin
          if (off_b[0]) begin
            run_add = run_add + {10'b0, bt};
            rep_add = rep_add + {10'b0, rb};
          end else begin
            run_add = run_add + {2'b0, bt, 8'b0};
            rep_add = rep_add + {2'b0, rb, 8'b0};
          end
        end
      end
    end

    // sums are associative under end-around carry, so a word folds in once
    run_d = icmp6rc_pkg::ones_fold({5'b0, run_d} + {3'b0, run_add});
    rep_d = icmp6rc_pkg::ones_fold({5'b0, rep_d} + {3'b0, rep_add});

    off_tot = {1'b0, base_off} + {{(17-icmp6rc_pkg::NB_W){1'b0}}, q_data_i.nbytes};
    off_d   = off_tot[16] ? 16'hFFFF : off_tot[15:0];

    csum = ~run_d;
    if (csum != 16'd0) begin
      res_d.verdict = icmp6rc_pkg::VERDICT_BAD_SUM;
    end else if (type_d == icmp6rc_pkg::TYPE_ECHO_REQ) begin
      res_d.verdict = icmp6rc_pkg::VERDICT_ECHO_REQ;
    end else if (type_d == icmp6rc_pkg::TYPE_ECHO_REP) begin
      res_d.verdict = icmp6rc_pkg::VERDICT_ECHO_REP;
    end else if (type_d == icmp6rc_pkg::TYPE_DEST_UNREACH ||
                 type_d == icmp6rc_pkg::TYPE_TIME_EXCEED) begin
      res_d.verdict = icmp6rc_pkg::VERDICT_ERROR;
    end else if (type_d == icmp6rc_pkg::TYPE_PKT_TOO_BIG) begin
      res_d.verdict = (len_d < icmp6rc_pkg::PTB_MIN_LEN) ? icmp6rc_pkg::VERDICT_TOO_SHORT
                                                         : icmp6rc_pkg::VERDICT_TOO_BIG;
    end else if (type_d >= icmp6rc_pkg::TYPE_NDP_FIRST &&
                 type_d <= icmp6rc_pkg::TYPE_NDP_LAST) begin
      res_d.verdict = icmp6rc_pkg::VERDICT_NDP;
    end else begin
      res_d.verdict = icmp6rc_pkg::VERDICT_UNKNOWN;
    end
    res_d.msg_type = type_d;
    res_d.msg_code = code_d;
    res_d.body     = body_d;
    res_d.csum     = csum;
    res_d.reply    = (res_d.verdict == icmp6rc_pkg::VERDICT_ECHO_REQ) ? ~rep_d : 16'd0;
    res_d.orig_hi  = orig_hi_d;
    res_d.orig_lo  = orig_lo_d;

    res_cnt_d = res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      rep_q     <= '0;
      off_q     <= '0;
      len_q     <= '0;
      type_q    <= '0;
      code_q    <= '0;
      body_q    <= '0;
      orig_hi_q <= '0;
      orig_lo_q <= '0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      if (go) begin
        run_q     <= run_d;
        rep_q     <= rep_d;
        off_q     <= off_d;
        len_q     <= len_d;
        type_q    <= type_d;
        code_q    <= code_d;
        body_q    <= body_d;
        orig_hi_q <= orig_hi_d;
        orig_lo_q <= orig_lo_d;
      end
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= 2'(icmp6rc_pkg::RES_DEPTH))
    else $error("result queue over-filled");

  a_first_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && q_data_i.first) |=> (off_q == 16'($past(q_data_i.nbytes))))
    else $error("byte offset not restarted on first word");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty)
    else $error("result transfer lost");

endmodule

/* dv/icmpv6_receive_checker_core_tb.sv */
// Testbench for icmpv6_receive_checker_core: builds ICMPv6 messages word by word, predicts
// each verdict with its own checksum model and compares every popped result field by field.
// Depends on icmp6rc_pkg for the result struct, verdict codes and type constants.
`timescale 1ns / 1ps

module icmpv6_receive_checker_core_tb;

  localparam int unsigned POP_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS    = 1450;
  localparam int unsigned LONG_WORDS      = 40;
  localparam int unsigned DRAIN_CYCLES    = 16;

  typedef enum {ADDR_RANDOM, ADDR_ONES, ADDR_ZERO} addr_kind_e;

  typedef struct {
    logic        first;
    logic        last;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic [15:0] plen;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } msg_word_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        push             = 1'b0;
  logic        full;
  logic        first_word_i     = 1'b0;
  logic        last_word_i      = 1'b0;
  logic [31:0] data_word_i      = '0;
  logic [2:0]  valid_bytes_i    = '0;
  logic [15:0] payload_length_i = '0;
  logic [63:0] src_addr_hi_i    = '0;
  logic [63:0] src_addr_lo_i    = '0;
  logic [63:0] dst_addr_hi_i    = '0;
  logic [63:0] dst_addr_lo_i    = '0;
  logic        empty;
  logic        pop              = 1'b0;
  logic [2:0]  verdict_o;
  logic [7:0]  msg_type_o;
  logic [7:0]  msg_code_o;
  logic [31:0] body_word_o;
  logic [15:0] computed_sum_o;
  logic [15:0] reply_checksum_o;
  logic [63:0] orig_dst_hi_o;
  logic [63:0] orig_dst_lo_o;

  // predictor state
  logic [31:0] csum_acc   = '0;
  logic [31:0] reply_acc  = '0;
  logic [15:0] byte_pos   = '0;
  logic [15:0] msg_len    = '0;
  logic [15:0] type_code  = '0;
  logic [31:0] body_cap   = '0;
  logic [63:0] orig_cap [2] = '{64'h0, 64'h0};

  icmp6rc_pkg::res_t pending_verdicts [$];
  int unsigned words_sent     = 0;
  int unsigned mismatches     = 0;
  bit          sender_steady  = 1'b0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned pop_hold_left  = 0;
  int unsigned pop_stall_left = 0;
  int unsigned pop_calm_left  = 0;

  icmpv6_receive_checker_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .first_word_i     (first_word_i),
    .last_word_i      (last_word_i),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .payload_length_i (payload_length_i),
    .src_addr_hi_i    (src_addr_hi_i),
    .src_addr_lo_i    (src_addr_lo_i),
    .dst_addr_hi_i    (dst_addr_hi_i),
    .dst_addr_lo_i    (dst_addr_lo_i),
    .empty            (empty),
    .pop              (pop),
    .verdict_o        (verdict_o),
    .msg_type_o       (msg_type_o),
    .msg_code_o       (msg_code_o),
    .body_word_o      (body_word_o),
    .computed_sum_o   (computed_sum_o),
    .reply_checksum_o (reply_checksum_o),
    .orig_dst_hi_o    (orig_dst_hi_o),
    .orig_dst_lo_o    (orig_dst_lo_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] fold16(input logic [31:0] s);
    logic [31:0] t;
    t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    return {16'h0, t[15:0]} + {16'h0, t[31:16]};
  endfunction

  function automatic logic [31:0] quad_sum(input logic [63:0] v);
    return {16'h0, v[15:0]} + {16'h0, v[31:16]} + {16'h0, v[47:32]} + {16'h0, v[63:48]};
  endfunction

  // pseudo-header: both addresses, upper-layer length and next header
  function automatic logic [31:0] pseudo_sum(input logic [63:0] sh, input logic [63:0] sl,
                                             input logic [63:0] dh, input logic [63:0] dl,
                                             input logic [15:0] len);
    logic [31:0] p;
    p = fold16(quad_sum(sh) + quad_sum(sl));
    p = fold16(p + quad_sum(dh) + quad_sum(dl));
    return fold16(p + {16'h0, len} + {16'h0, icmp6rc_pkg::NEXT_HDR_ICMPV6});
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic msg_word_t random_word();
    msg_word_t w;
    w.first  = 1'($urandom_range(0, 1));
    w.last   = 1'($urandom_range(0, 1));
    w.data   = $urandom;
    w.nbytes = 3'($urandom_range(0, 7));
    w.plen   = 16'($urandom);
    w.src_hi = {$urandom, $urandom};
    w.src_lo = {$urandom, $urandom};
    w.dst_hi = {$urandom, $urandom};
    w.dst_lo = {$urandom, $urandom};
    return w;
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 11))
      0, 1: return icmp6rc_pkg::TYPE_ECHO_REQ;
      2: return icmp6rc_pkg::TYPE_ECHO_REP;
      3: return icmp6rc_pkg::TYPE_DEST_UNREACH;
      4: return icmp6rc_pkg::TYPE_TIME_EXCEED;
      5, 6: return icmp6rc_pkg::TYPE_PKT_TOO_BIG;
      7: return icmp6rc_pkg::TYPE_NDP_FIRST;
      8: return icmp6rc_pkg::TYPE_NDP_LAST;
      9: return icmp6rc_pkg::TYPE_NDP_FIRST + 8'($urandom_range(1, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0]  rb;
    logic [31:0] lane;
    logic [31:0] rlane;
    int unsigned off;
    int unsigned slot;
    off = 32'(byte_pos);
    rb  = b;
    // the echo reply swaps the type to 129 and zeroes its checksum field
    if (off == 0) begin
      type_code[15:8] = b;
      rb = icmp6rc_pkg::TYPE_ECHO_REP;
    end else if (off == 1) begin
      type_code[7:0] = b;
    end else if (off == 2 || off == 3) begin
      rb = 8'h00;
    end else if (off >= 4 && off <= 7) begin
      body_cap[8*(7-off) +: 8] = b;
    end else if (off >= 32 && off <= 47) begin
      slot = off - 32;
      orig_cap[slot >> 3][8*(7 - (slot % 8)) +: 8] = b;
    end
    // bytes past the stated length are captured but not summed
    if (off < 32'(msg_len)) begin
      lane      = (off % 2) ? {24'h0, b} : {16'h0, b, 8'h0};
      rlane     = (off % 2) ? {24'h0, rb} : {16'h0, rb, 8'h0};
      csum_acc  = fold16(csum_acc + lane);
      reply_acc = fold16(reply_acc + rlane);
    end
    if (byte_pos != 16'hFFFF) byte_pos++;
  endtask

  task automatic predict_verdict(input msg_word_t w, output bit produced,
                                 output icmp6rc_pkg::res_t r);
    int unsigned take;
    int unsigned i;
    logic [7:0]  mtype;
    if (w.first) begin
      msg_len     = w.plen;
      byte_pos    = '0;
      type_code   = '0;
      body_cap    = '0;
      orig_cap[0] = '0;
      orig_cap[1] = '0;
      csum_acc    = pseudo_sum(w.src_hi, w.src_lo, w.dst_hi, w.dst_lo, w.plen);
      reply_acc   = csum_acc;
    end
    take = (32'(w.nbytes) > icmp6rc_pkg::WORD_BYTES) ? icmp6rc_pkg::WORD_BYTES
                                                      : 32'(w.nbytes);
    for (i = 0; i < take; i++) absorb_byte(w.data[8*(icmp6rc_pkg::WORD_BYTES-1-i) +: 8]);
    produced = w.last;
    r = '0;
    if (w.last) begin
      mtype      = type_code[15:8];
      r.msg_type = mtype;
      r.msg_code = type_code[7:0];
      r.body     = body_cap;
      r.csum     = ~csum_acc[15:0];
      r.orig_hi  = orig_cap[0];
      r.orig_lo  = orig_cap[1];
      if (r.csum != 16'h0) r.verdict = icmp6rc_pkg::VERDICT_BAD_SUM;
      else if (mtype == icmp6rc_pkg::TYPE_ECHO_REQ) r.verdict = icmp6rc_pkg::VERDICT_ECHO_REQ;
      else if (mtype == icmp6rc_pkg::TYPE_ECHO_REP) r.verdict = icmp6rc_pkg::VERDICT_ECHO_REP;
      else if (mtype == icmp6rc_pkg::TYPE_DEST_UNREACH ||
               mtype == icmp6rc_pkg::TYPE_TIME_EXCEED)
        r.verdict = icmp6rc_pkg::VERDICT_ERROR;
      else if (mtype == icmp6rc_pkg::TYPE_PKT_TOO_BIG)
        r.verdict = (msg_len < icmp6rc_pkg::PTB_MIN_LEN) ? icmp6rc_pkg::VERDICT_TOO_SHORT
                                                         : icmp6rc_pkg::VERDICT_TOO_BIG;
      else if (mtype >= icmp6rc_pkg::TYPE_NDP_FIRST && mtype <= icmp6rc_pkg::TYPE_NDP_LAST)
        r.verdict = icmp6rc_pkg::VERDICT_NDP;
      else r.verdict = icmp6rc_pkg::VERDICT_UNKNOWN;
      if (r.verdict == icmp6rc_pkg::VERDICT_ECHO_REQ) r.reply = ~reply_acc[15:0];
    end
  endtask

  // one input transfer, then an optional gap; push stays up when no gap follows
  task automatic send_word(input msg_word_t w);
    bit                produced;
    icmp6rc_pkg::res_t r;
    int unsigned       gap;
    push             <= 1'b1;
    first_word_i     <= w.first;
    last_word_i      <= w.last;
    data_word_i      <= w.data;
    valid_bytes_i    <= w.nbytes;
    payload_length_i <= w.plen;
    src_addr_hi_i    <= w.src_hi;
    src_addr_lo_i    <= w.src_lo;
    dst_addr_hi_i    <= w.dst_hi;
    dst_addr_lo_i    <= w.dst_lo;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_verdict(w, produced, r);
    if (produced) pending_verdicts.push_back(r);
    words_sent++;
    gap = sender_steady ? 0 : draw_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // builds a message with a correct checksum for the stated length, then splits it into words
  task automatic send_message(input logic [7:0] mtype, input logic [7:0] mcode,
                              input int unsigned nbytes, input logic [15:0] plen,
                              input bit corrupt, input bit ragged, input bit with_first,
                              input bit with_last, input addr_kind_e addr_kind);
    logic [7:0]  msg [$];
    logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
    logic [31:0] acc;
    logic [15:0] csum;
    int unsigned k, pos, take, vb;
    bit          opening;
    msg_word_t   w;
    case (addr_kind)
      ADDR_ONES: {src_hi, src_lo, dst_hi, dst_lo} = {256{1'b1}};
      ADDR_ZERO: {src_hi, src_lo, dst_hi, dst_lo} = '0;
      default: begin
        src_hi = {$urandom, $urandom};
        src_lo = {$urandom, $urandom};
        dst_hi = {$urandom, $urandom};
        dst_lo = {$urandom, $urandom};
      end
    endcase
    for (k = 0; k < nbytes; k++) msg.push_back(8'($urandom));
    if (nbytes > 0) msg[0] = mtype;
    if (nbytes > 1) msg[1] = mcode;
    if (nbytes > 3) begin
      msg[2] = 8'h00;
      msg[3] = 8'h00;
      acc = pseudo_sum(src_hi, src_lo, dst_hi, dst_lo, plen);
      for (k = 0; k < nbytes && k < 32'(plen); k++)
        acc = fold16(acc + ((k % 2) ? {24'h0, msg[k]} : {16'h0, msg[k], 8'h0}));
      csum   = ~acc[15:0];
      msg[2] = csum[15:8];
      msg[3] = csum[7:0];
    end
    if (corrupt && nbytes != 0) begin
      k = $urandom_range(0, nbytes - 1);
      msg[k] = msg[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    pos     = 0;
    opening = 1'b1;
    while (opening || pos < nbytes) begin
      w  = random_word();
      vb = ragged ? $urandom_range(0, 7) : icmp6rc_pkg::WORD_BYTES;
      take = (vb > icmp6rc_pkg::WORD_BYTES) ? icmp6rc_pkg::WORD_BYTES : vb;
      if (take > nbytes - pos) begin
        take = nbytes - pos;
        vb   = take;
      end
      if ($urandom_range(0, 1)) w.data = '0;
      for (k = 0; k < take; k++)
        w.data[8*(icmp6rc_pkg::WORD_BYTES-1-k) +: 8] = msg[pos + k];
      pos     += take;
      w.nbytes = 3'(vb);
      w.first  = opening && with_first;
      w.last   = (pos >= nbytes) && with_last;
      if (opening) begin
        w.plen   = plen;
        w.src_hi = src_hi;
        w.src_lo = src_lo;
        w.dst_hi = dst_hi;
        w.dst_lo = dst_lo;
      end
      opening = 1'b0;
      send_word(w);
    end
  endtask

  task automatic test_verdicts();
    send_message(icmp6rc_pkg::TYPE_ECHO_REQ, 8'h00, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_ONES);
    send_message(icmp6rc_pkg::TYPE_ECHO_REP, 8'hFF, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_ZERO);
    send_message(icmp6rc_pkg::TYPE_DEST_UNREACH, 8'h04, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    // packet too big below the minimum length, then one that claims the minimum
    send_message(icmp6rc_pkg::TYPE_PKT_TOO_BIG, 8'h00, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    send_message(icmp6rc_pkg::TYPE_PKT_TOO_BIG, 8'h00, 8, icmp6rc_pkg::PTB_MIN_LEN, 1'b0, 1'b0,
                 1'b1, 1'b1, ADDR_RANDOM);
    send_message(icmp6rc_pkg::TYPE_NDP_FIRST, 8'h00, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    send_message(icmp6rc_pkg::TYPE_NDP_LAST, 8'h00, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    send_message(8'hFF, 8'h00, 8, 16'd8, 1'b0, 1'b0, 1'b1, 1'b1, ADDR_RANDOM);
  endtask

  task automatic test_corner_words();
    msg_word_t w;
    send_message(icmp6rc_pkg::TYPE_TIME_EXCEED, 8'h01, 9, 16'd9, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    send_message(icmp6rc_pkg::TYPE_ECHO_REQ, 8'h00, 8, 16'd8, 1'b1, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    // trailing bytes beyond the stated length
    send_message(icmp6rc_pkg::TYPE_ECHO_REQ, 8'h00, 8, 16'd6, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
    // byte count above the word size, then a word carrying nothing
    w        = random_word();
    w.first  = 1'b1;
    w.last   = 1'b0;
    w.nbytes = 3'd7;
    w.data   = 32'hFFFF_FFFF;
    w.plen   = 16'd0;
    send_word(w);
    w        = random_word();
    w.first  = 1'b0;
    w.last   = 1'b1;
    w.nbytes = 3'd0;
    w.data   = 32'h0;
    send_word(w);
  endtask

  task automatic test_random_messages();
    int unsigned target, roll, nbytes, cnt, k;
    logic [7:0]  mtype;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      roll          = $urandom_range(0, 99);
      sender_steady = ($urandom_range(0, 7) == 0);
      mtype         = pick_type();
      case ($urandom_range(0, 9))
        0: nbytes = $urandom_range(0, 7);
        1, 2: nbytes = $urandom_range(40, 56);
        3: nbytes = $urandom_range(65, 200);
        default: nbytes = $urandom_range(8, 64);
      endcase
      if (roll < 70)
        send_message(mtype, 8'($urandom), nbytes, 16'(nbytes), 1'b0,
                     ($urandom_range(0, 3) == 0), 1'b1, 1'b1, ADDR_RANDOM);
      else if (roll < 76)
        send_message(mtype, 8'($urandom), nbytes, 16'(nbytes), 1'b1, 1'b0, 1'b1, 1'b1,
                     ADDR_RANDOM);
      else if (roll < 82)
        send_message(mtype, 8'($urandom), nbytes, 16'($urandom_range(0, nbytes + 16)), 1'b0,
                     1'($urandom_range(0, 1)), 1'b1, 1'b1, ADDR_RANDOM);
      else if (roll < 87)
        send_message(mtype, 8'($urandom), nbytes, 16'(nbytes), 1'b0, 1'b0, 1'b0, 1'b1,
                     ADDR_RANDOM);
      else if (roll < 92)
        send_message(mtype, 8'($urandom), nbytes, 16'(nbytes), 1'b0, 1'b0, 1'b1, 1'b0,
                     ADDR_RANDOM);
      else begin
        cnt = $urandom_range(1, 4);
        for (k = 0; k < cnt; k++) send_word(random_word());
      end
    end
    sender_steady = 1'b0;
  endtask

  // result side held off long enough for both queues to fill and raise full
  task automatic test_backpressure();
    int unsigned k;
    hold_reqs++;
    sender_steady = 1'b1;
    for (k = 0; k < 40; k++)
      send_message(pick_type(), 8'($urandom), 4, 16'd4, 1'b0, 1'b0, 1'b1, 1'b1, ADDR_RANDOM);
    sender_steady = 1'b0;
  endtask

  // a long message well past the captured fields, then a fresh message restarts cleanly
  task automatic test_long_stream();
    msg_word_t   w;
    int unsigned k;
    sender_steady = 1'b1;
    for (k = 0; k < LONG_WORDS; k++) begin
      w        = random_word();
      w.first  = (k == 0);
      w.last   = (k == LONG_WORDS - 1);
      w.nbytes = 3'(icmp6rc_pkg::WORD_BYTES);
      if (k == 0) w.plen = 16'hFFFF;
      send_word(w);
    end
    sender_steady = 1'b0;
    send_message(icmp6rc_pkg::TYPE_ECHO_REQ, 8'h00, 12, 16'd12, 1'b0, 1'b0, 1'b1, 1'b1,
                 ADDR_RANDOM);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen     = hold_reqs;
      pop_hold_left = POP_HOLD_CYCLES;
    end
    if (pop_hold_left != 0) begin
      pop_hold_left--;
      pop <= 1'b0;
    end else if (pop_stall_left != 0) begin
      pop_stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (pop_calm_left != 0) pop_calm_left--;
      else if ($urandom_range(0, 5) == 0) pop_stall_left = draw_gap() + 1;
      else if ($urandom_range(0, 63) == 0) pop_calm_left = $urandom_range(50, 200);
    end
  end

  always @(posedge clk_i) begin
    icmp6rc_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing expected, verdict %0d type %0d",
                   $realtime, verdict_o, msg_type_o);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 64'(want.verdict), 64'(verdict_o));
        check_field("msg_type", 64'(want.msg_type), 64'(msg_type_o));
        check_field("msg_code", 64'(want.msg_code), 64'(msg_code_o));
        check_field("body_word", 64'(want.body), 64'(body_word_o));
        check_field("computed_sum", 64'(want.csum), 64'(computed_sum_o));
        check_field("reply_checksum", 64'(want.reply), 64'(reply_checksum_o));
        check_field("orig_dst_hi", want.orig_hi, orig_dst_hi_o);
        check_field("orig_dst_lo", want.orig_lo, orig_dst_lo_o);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_verdicts();
    test_corner_words();
    test_random_messages();
    test_backpressure();
    test_long_stream();
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
